### design/pei_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pei_pkg: shared types and constants of the 2D particle Euler integrator
// Payload structs, opcodes, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package pei_pkg;

   localparam int DATA_W    = 32;
   localparam int DT_W      = 16;
   localparam int DT_BITS   = 16;
   localparam int FRAC_BITS = 16;
   localparam int MUL_W     = DATA_W + 1;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] OP_ADD_FORCE = 2'd0;
   localparam logic [1:0] OP_INTEGRATE = 2'd1;
   localparam logic [1:0] OP_LOAD      = 2'd2;
   localparam logic [1:0] OP_NONE      = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_INV_MASS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_X  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_Y  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED   = 2'd3;

   typedef struct packed {
      logic        [1:0]        op;
      logic signed [DATA_W-1:0] force_x;
      logic signed [DATA_W-1:0] force_y;
      logic        [DT_W-1:0]   dt;
      logic signed [DATA_W-1:0] load_pos_x;
      logic signed [DATA_W-1:0] load_pos_y;
      logic signed [DATA_W-1:0] load_vel_x;
      logic signed [DATA_W-1:0] load_vel_y;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
      logic                     skipped;
      logic                     saturated;
   } rsp_type;

endpackage
`default_nettype wire

### design/pei_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pei_mul: shared signed multiplier
// 33x33 signed product, registered; the top 2 bits are never significant.
// ----------------------------------------------------------------------------
module pei_mul (
   input  wire logic                               clock,
   input  wire logic signed [pei_pkg::MUL_W-1:0]   mul_a,
   input  wire logic signed [pei_pkg::MUL_W-1:0]   mul_b,
   output logic signed      [pei_pkg::PROD_W-1:0]  product
);

   logic signed [2*pei_pkg::MUL_W-1:0] full_prod;
   logic signed [pei_pkg::PROD_W-1:0]  product_ff;
   logic signed [pei_pkg::PROD_W-1:0]  product_in;

   assign full_prod  = mul_a * mul_b;
   assign product_in = full_prod[pei_pkg::PROD_W-1:0];
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule
`default_nettype wire

### design/pei_sat_add.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pei_sat_add: shared saturating adder
// Exact 32 + 64 bit sum, clamped to the signed 32-bit range.
// ----------------------------------------------------------------------------
module pei_sat_add (
   input  wire logic signed [pei_pkg::DATA_W-1:0] add_a,
   input  wire logic signed [pei_pkg::PROD_W-1:0] add_b,
   output logic signed      [pei_pkg::DATA_W-1:0] add_sum,
   output logic                                   add_sat
);

   localparam int DW = pei_pkg::DATA_W;
   localparam int SW = pei_pkg::SUM_W;

   logic signed [SW-1:0] sum_full;
   logic                 over_hi;
   logic                 over_lo;

   assign sum_full = {{(SW-DW){add_a[DW-1]}}, add_a} + {add_b[pei_pkg::PROD_W-1], add_b};
   assign over_hi  = !sum_full[SW-1] && (sum_full[SW-2:DW-1] != '0);
   assign over_lo  = sum_full[SW-1] && (sum_full[SW-2:DW-1] != '1);
   assign add_sat  = over_hi || over_lo;

   always_comb begin
      priority if (over_hi) begin
         add_sum = {1'b0, {(DW-1){1'b1}}};
      end else if (over_lo) begin
         add_sum = {1'b1, {(DW-1){1'b0}}};
      end else begin
         add_sum = sum_full[DW-1:0];
      end
   end

endmodule
`default_nettype wire

### design/particle_euler_integrator_2d.sv
// Each request runs through the exec steps and the output state before rsp_valid;
// the next request is taken only once the result is in the output register,
// so an output stall holds it off. One shared multiplier and adder serve all steps.
// Reset (synchronous, active high) clears state and accumulator to zero,
// inverse mass to 1.0 and acceleration to zero.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_euler_integrator_2d: 2D point-mass Euler integrator
// Sequencer around one multiplier and one saturating adder.
// ----------------------------------------------------------------------------
module particle_euler_integrator_2d #(
   parameter int FRAC_BITS = pei_pkg::FRAC_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire pei_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output pei_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [pei_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pei_pkg::DATA_W-1:0]          csr_wdata
);

   localparam int DW = pei_pkg::DATA_W;
   localparam int PW = pei_pkg::PROD_W;

   localparam logic [2:0] STEP_MUL_VX = 3'd0;
   localparam logic [2:0] STEP_POS_X  = 3'd1;
   localparam logic [2:0] STEP_POS_Y  = 3'd2;
   localparam logic [2:0] STEP_ACC_X  = 3'd3;
   localparam logic [2:0] STEP_ACC_Y  = 3'd4;
   localparam logic [2:0] STEP_VEL_X  = 3'd5;
   localparam logic [2:0] STEP_VEL_Y  = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type                 state_ff, state_in;
   logic [2:0]                step_ff, step_in;
   pei_pkg::req_type          req_ff, req_in;
   logic signed [DW-1:0]      pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [DW-1:0]      vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [DW-1:0]      fs_x_ff, fs_x_in, fs_y_ff, fs_y_in;
   logic signed [DW-1:0]      acc_ff, acc_in;
   logic [DW-1:0]             inv_mass_ff, inv_mass_in;
   logic signed [DW-1:0]      accel_x_ff, accel_x_in, accel_y_ff, accel_y_in;
   logic                      sat_ff, sat_in, skip_ff, skip_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   pei_pkg::rsp_type          rsp_ff, rsp_in;

   logic signed [pei_pkg::MUL_W-1:0] mul_a, mul_b;
   logic signed [PW-1:0]             product;
   logic signed [PW-1:0]             prod_shr;
   logic signed [DW-1:0]             add_a;
   logic signed [PW-1:0]             add_b;
   logic signed [DW-1:0]             add_sum;
   logic                             add_sat;
   logic signed [pei_pkg::MUL_W-1:0] dt_ext, im_ext;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign dt_ext = {{(pei_pkg::MUL_W-pei_pkg::DT_W){1'b0}}, req_ff.dt};
   assign im_ext = {1'b0, inv_mass_ff};

   always_comb begin
      unique case (step_ff)
         STEP_MUL_VX: begin mul_a = {vel_x_ff[DW-1], vel_x_ff}; mul_b = dt_ext; end
         STEP_POS_X:  begin mul_a = {vel_y_ff[DW-1], vel_y_ff}; mul_b = dt_ext; end
         STEP_POS_Y:  begin mul_a = {fs_x_ff[DW-1], fs_x_ff};   mul_b = im_ext; end
         STEP_ACC_X:  begin mul_a = {fs_y_ff[DW-1], fs_y_ff};   mul_b = im_ext; end
         default:     begin mul_a = {acc_ff[DW-1], acc_ff};     mul_b = dt_ext; end
      endcase
   end

   pei_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   assign prod_shr = (step_ff == STEP_ACC_X || step_ff == STEP_ACC_Y) ?
                     (product >>> FRAC_BITS) : (product >>> pei_pkg::DT_BITS);

   always_comb begin
      add_b = prod_shr;
      if (req_ff.op == pei_pkg::OP_ADD_FORCE) begin
         add_b = (step_ff == STEP_MUL_VX) ?
                 {{(PW-DW){req_ff.force_x[DW-1]}}, req_ff.force_x} :
                 {{(PW-DW){req_ff.force_y[DW-1]}}, req_ff.force_y};
      end
   end

   always_comb begin
      unique case (step_ff)
         STEP_MUL_VX: add_a = fs_x_ff;
         STEP_POS_X:  add_a = (req_ff.op == pei_pkg::OP_ADD_FORCE) ? fs_y_ff : pos_x_ff;
         STEP_POS_Y:  add_a = pos_y_ff;
         STEP_ACC_X:  add_a = accel_x_ff;
         STEP_ACC_Y:  add_a = accel_y_ff;
         STEP_VEL_X:  add_a = vel_x_ff;
         default:     add_a = vel_y_ff;
      endcase
   end

   pei_sat_add u_add (
      .add_a   (add_a),
      .add_b   (add_b),
      .add_sum (add_sum),
      .add_sat (add_sat)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      req_in       = req_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      vel_x_in     = vel_x_ff;
      vel_y_in     = vel_y_ff;
      fs_x_in      = fs_x_ff;
      fs_y_in      = fs_y_ff;
      acc_in       = acc_ff;
      inv_mass_in  = inv_mass_ff;
      accel_x_in   = accel_x_ff;
      accel_y_in   = accel_y_ff;
      sat_in       = sat_ff;
      skip_in      = skip_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_we) begin
         unique case (csr_index)
            pei_pkg::CSR_INV_MASS: inv_mass_in = csr_wdata;
            pei_pkg::CSR_ACCEL_X:  accel_x_in  = csr_wdata;
            pei_pkg::CSR_ACCEL_Y:  accel_y_in  = csr_wdata;
            pei_pkg::CSR_UNUSED:   ;
            default:               ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               sat_in   = 1'b0;
               skip_in  = 1'b0;
               step_in  = STEP_MUL_VX;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            step_in = step_ff + 3'd1;
            unique case (req_ff.op)
               pei_pkg::OP_ADD_FORCE: begin
                  sat_in = sat_ff | add_sat;
                  if (step_ff == STEP_MUL_VX) begin
                     fs_x_in = add_sum;
                  end else begin
                     fs_y_in  = add_sum;
                     state_in = ST_OUT;
                  end
               end
               pei_pkg::OP_INTEGRATE: begin
                  if (inv_mass_ff == '0) begin
                     skip_in  = 1'b1;
                     state_in = ST_OUT;
                  end else begin
                     if (step_ff != STEP_MUL_VX) begin
                        sat_in = sat_ff | add_sat;
                     end
                     unique case (step_ff)
                        STEP_MUL_VX: ;
                        STEP_POS_X:  pos_x_in = add_sum;
                        STEP_POS_Y:  pos_y_in = add_sum;
                        STEP_ACC_X:  acc_in   = add_sum;
                        STEP_ACC_Y:  acc_in   = add_sum;
                        STEP_VEL_X:  vel_x_in = add_sum;
                        default: begin
                           vel_y_in = add_sum;
                           fs_x_in  = '0;
                           fs_y_in  = '0;
                           state_in = ST_OUT;
                        end
                     endcase
                  end
               end
               pei_pkg::OP_LOAD: begin
                  pos_x_in = req_ff.load_pos_x;
                  pos_y_in = req_ff.load_pos_y;
                  vel_x_in = req_ff.load_vel_x;
                  vel_y_in = req_ff.load_vel_y;
                  state_in = ST_OUT;
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.pos_x     = pos_x_ff;
               rsp_in.pos_y     = pos_y_ff;
               rsp_in.vel_x     = vel_x_ff;
               rsp_in.vel_y     = vel_y_ff;
               rsp_in.skipped   = skip_ff;
               rsp_in.saturated = sat_ff;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_MUL_VX;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         fs_x_ff      <= '0;
         fs_y_ff      <= '0;
         inv_mass_ff  <= DW'(64'd1 << FRAC_BITS);
         accel_x_ff   <= '0;
         accel_y_ff   <= '0;
         sat_ff       <= 1'b0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
         fs_x_ff      <= fs_x_in;
         fs_y_ff      <= fs_y_in;
         inv_mass_ff  <= inv_mass_in;
         accel_x_ff   <= accel_x_in;
         accel_y_ff   <= accel_y_in;
         sat_ff       <= sat_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
   end

   // a waiting beat is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("rsp beat lost");

   // a new beat only comes out of the output state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("rsp beat without sequencer");

   // the sequencer never runs past the last integrate step
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |-> step_ff <= STEP_VEL_Y)
      else $error("step out of range");

   // an immovable integrate never clamps
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.skipped && rsp_ff.saturated))
      else $error("skipped and saturated together");

endmodule
`default_nettype wire

### test/particle_euler_integrator_2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_euler_integrator_2d_checker: result checker for the 2D integrator
// Watches the register port and both channels, keeps its own copy of the
// particle state, works out the state each beat should report and compares
// every returned beat field by field, in order.
// ----------------------------------------------------------------------------
module particle_euler_integrator_2d_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire pei_pkg::req_type               req_data,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire pei_pkg::rsp_type               rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [pei_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pei_pkg::DATA_W-1:0]     csr_wdata,
   output int                                  mismatches,
   output int                                  pending
);
   import pei_pkg::*;

   localparam longint WIDE_MAX = 64'sd2147483647;
   localparam longint WIDE_MIN = -64'sd2147483648;
   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam int PRINT_CAP = 40;

   // index 0 is x, 1 is y
   logic signed [DATA_W-1:0] pos [2];
   logic signed [DATA_W-1:0] vel [2];
   logic signed [DATA_W-1:0] frc [2];
   logic signed [DATA_W-1:0] accel_cfg [2];
   logic        [DATA_W-1:0] inv_mass_cfg;

   rsp_type due_states [$];
   bit      sum_clamped;
   int      results_seen = 0;

   function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] base,
                                                        input longint delta);
      longint total;
      total = longint'(base) + delta;
      if (total > WIDE_MAX) begin
         sum_clamped = 1'b1;
         return Q_MAX;
      end
      if (total < WIDE_MIN) begin
         sum_clamped = 1'b1;
         return Q_MIN;
      end
      return total[DATA_W-1:0];
   endfunction

   task automatic advance_particle(input req_type item, output rsp_type state_out);
      logic signed [DATA_W-1:0] accel_now;
      longint                   force_term;
      logic                     idle_mass;
      idle_mass   = 1'b0;
      sum_clamped = 1'b0;
      case (item.op)
         OP_ADD_FORCE: begin
            frc[0] = sat_add(frc[0], longint'(item.force_x));
            frc[1] = sat_add(frc[1], longint'(item.force_y));
         end
         OP_INTEGRATE: begin
            if (inv_mass_cfg == '0) begin
               idle_mass = 1'b1;
            end else begin
               // position moves on the old velocity
               for (int k = 0; k < 2; k++)
                  pos[k] = sat_add(pos[k], (longint'(vel[k]) * longint'(item.dt)) >>> DT_BITS);
               for (int k = 0; k < 2; k++) begin
                  force_term = (longint'(frc[k]) * longint'(inv_mass_cfg)) >>> FRAC_BITS;
                  accel_now  = sat_add(accel_cfg[k], force_term);
                  vel[k]     = sat_add(vel[k], (longint'(accel_now) * longint'(item.dt)) >>> DT_BITS);
                  frc[k]     = '0;
               end
            end
         end
         OP_LOAD: begin
            pos[0] = item.load_pos_x;
            pos[1] = item.load_pos_y;
            vel[0] = item.load_vel_x;
            vel[1] = item.load_vel_y;
         end
         default: ;
      endcase
      state_out.pos_x     = pos[0];
      state_out.pos_y     = pos[1];
      state_out.vel_x     = vel[0];
      state_out.vel_y     = vel[1];
      state_out.skipped   = idle_mass;
      state_out.saturated = sum_clamped;
   endtask

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t ns: result %0d %s: got %h, expected %h", $time, results_seen, what,
                  got, want);
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type got;
      if (reset) begin
         for (int k = 0; k < 2; k++) begin
            pos[k]       = '0;
            vel[k]       = '0;
            frc[k]       = '0;
            accel_cfg[k] = '0;
         end
         inv_mass_cfg = 32'h0001_0000;
         due_states.delete();
         pending = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            got = rsp_data;
            if (due_states.size() == 0) begin
               report_mismatch("beat with nothing due", '0, '0);
            end else begin
               want = due_states.pop_front();
               if (got.pos_x !== want.pos_x)
                  report_mismatch("pos_x", got.pos_x, want.pos_x);
               if (got.pos_y !== want.pos_y)
                  report_mismatch("pos_y", got.pos_y, want.pos_y);
               if (got.vel_x !== want.vel_x)
                  report_mismatch("vel_x", got.vel_x, want.vel_x);
               if (got.vel_y !== want.vel_y)
                  report_mismatch("vel_y", got.vel_y, want.vel_y);
               if (got.skipped !== want.skipped)
                  report_mismatch("skipped", DATA_W'(got.skipped), DATA_W'(want.skipped));
               if (got.saturated !== want.saturated)
                  report_mismatch("saturated", DATA_W'(got.saturated),
                                  DATA_W'(want.saturated));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_INV_MASS: inv_mass_cfg = csr_wdata;
               CSR_ACCEL_X:  accel_cfg[0] = csr_wdata;
               CSR_ACCEL_Y:  accel_cfg[1] = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_particle(req_data, want);
            due_states.push_back(want);
         end
         pending = due_states.size();
      end
   end

endmodule

### test/particle_euler_integrator_2d_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_euler_integrator_2d_tb: testbench top for the 2D Euler integrator
// Drives a directed run over the operand extremes, immovable mass, unused
// opcode, zero step and saturation, then randomized force/integrate frames
// under several register settings and handshake idling patterns, including
// a long output stall. The checker beside the block scores every beat.
// ----------------------------------------------------------------------------
module particle_euler_integrator_2d_tb;
   import pei_pkg::*;

   localparam int IDLE_LIMIT  = 5000;
   localparam int HOLD_CYCLES = 240;
   localparam int TAIL_CYCLES = 20;
   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_wdata = '0;

   int mismatches;
   int pending;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit hold_rsp     = 1'b0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   particle_euler_integrator_2d dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   particle_euler_integrator_2d_checker motion_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // result side: random stalls, or one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic signed [DATA_W-1:0] rand_q16();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: return Q_MIN;
               1: return Q_MAX;
               2: return '0;
               default: return -32'sd1;
            endcase
         end
         1, 2: return $urandom;
         default: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   function automatic logic [DT_W-1:0] rand_dt();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2, 3: return DT_W'($urandom);
         default: return DT_W'($urandom_range(16'h0800));
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] rand_inv_mass();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return Q_ONE;
         3: return $urandom;
         default: return $urandom_range(32'h0004_0000);
      endcase
   endfunction

   function automatic req_type make_item(input logic [1:0] op);
      req_type item;
      item.op         = op;
      item.force_x    = rand_q16();
      item.force_y    = rand_q16();
      item.dt         = rand_dt();
      item.load_pos_x = rand_q16();
      item.load_pos_y = rand_q16();
      item.load_vel_x = rand_q16();
      item.load_vel_y = rand_q16();
      return item;
   endfunction

   function automatic req_type set_item(input logic [1:0] op,
                                        input logic signed [DATA_W-1:0] fx, fy,
                                        input logic [DT_W-1:0] dt,
                                        input logic signed [DATA_W-1:0] px, py, vx, vy);
      req_type item;
      item.op         = op;
      item.force_x    = fx;
      item.force_y    = fy;
      item.dt         = dt;
      item.load_pos_x = px;
      item.load_pos_y = py;
      item.load_vel_x = vx;
      item.load_vel_y = vy;
      return item;
   endfunction

   task automatic offer(input req_type item);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic configure(input logic [DATA_W-1:0] inv_mass,
                            input logic signed [DATA_W-1:0] ax, ay);
      drain();
      write_reg(CSR_INV_MASS, inv_mass);
      write_reg(CSR_ACCEL_X, ax);
      write_reg(CSR_ACCEL_Y, ay);
   endtask

   // mostly force/integrate frames, some loads and stray opcodes
   task automatic run_frames(input int count);
      int         done;
      int         adds;
      logic [1:0] op_pick;
      done = 0;
      while (done < count) begin
         case ($urandom_range(9))
            0: begin
               offer(make_item(OP_LOAD));
               done++;
            end
            1: begin
               op_pick = 2'($urandom_range(3));
               offer(make_item(op_pick));
               done++;
            end
            default: begin
               adds = $urandom_range(3);
               repeat (adds) begin
                  offer(make_item(OP_ADD_FORCE));
                  done++;
               end
               offer(make_item(OP_INTEGRATE));
               done++;
            end
         endcase
      end
   endtask

   task automatic run_phase(input int req_pct, rsp_pct, count);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      repeat (4) begin
         configure(rand_inv_mass(), rand_q16(), rand_q16());
         run_frames(count / 4);
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed
      req_idle_pct = 10;
      rsp_idle_pct = 30;
      offer(set_item(OP_NONE, Q_MAX, Q_MIN, '1, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
      offer(set_item(OP_INTEGRATE, Q_MAX, Q_MIN, '0, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
      offer(set_item(OP_ADD_FORCE, Q_MAX, Q_MIN, '1, '0, '0, '0, '0));
      offer(set_item(OP_ADD_FORCE, Q_MAX, Q_MIN, '0, '0, '0, '0, '0));
      offer(set_item(OP_ADD_FORCE, Q_MIN, Q_MAX, '0, '0, '0, '0, '0));
      offer(set_item(OP_LOAD, Q_MIN, Q_MAX, '1, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
      offer(set_item(OP_INTEGRATE, '0, '0, '1, '0, '0, '0, '0));
      offer(set_item(OP_ADD_FORCE, Q_ONE, -Q_ONE, '0, '0, '0, '0, '0));
      offer(set_item(OP_INTEGRATE, '0, '0, '0, '0, '0, '0, '0));
      // immovable: accumulator must survive integrate
      configure('0, Q_MAX, Q_MIN);
      offer(set_item(OP_ADD_FORCE, 32'sh0005_0000, 32'sh0003_0000, '0, '0, '0, '0, '0));
      offer(set_item(OP_INTEGRATE, '0, '0, 16'h8000, '0, '0, '0, '0));
      offer(set_item(OP_NONE, '0, '0, '0, '0, '0, '0, '0));
      configure('1, Q_MAX, Q_MIN);
      offer(set_item(OP_INTEGRATE, '0, '0, '1, '0, '0, '0, '0));
      offer(set_item(OP_LOAD, '0, '0, '0, '0, '0, Q_MIN, Q_MAX));
      offer(set_item(OP_ADD_FORCE, Q_MIN, Q_MIN, '0, '0, '0, '0, '0));
      offer(set_item(OP_INTEGRATE, '0, '0, '1, '0, '0, '0, '0));
      drain();
      write_reg(CSR_UNUSED, $urandom);
      configure(Q_ONE, '0, '0);
      offer(set_item(OP_LOAD, '0, '0, '0, 32'sh0001_8000, -32'sh0002_0000,
                     32'sh0000_4000, -32'sh0000_c000));
      offer(set_item(OP_ADD_FORCE, -32'sh0000_0003, 32'sh0000_0007, '0, '0, '0, '0, '0));
      offer(set_item(OP_INTEGRATE, '0, '0, 16'h0001, '0, '0, '0, '0));
      offer(set_item(OP_INTEGRATE, '0, '0, '1, '0, '0, '0, '0));

      // random
      run_phase(23, 64, 480);
      run_phase(64, 23, 480);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      @(negedge clock);
      hold_rsp = 1'b1;
      run_frames(40);
      drain();
      run_phase(0, 0, 450);

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### filelist.f
design/pei_pkg.sv
design/pei_mul.sv
design/pei_sat_add.sv
design/particle_euler_integrator_2d.sv
test/particle_euler_integrator_2d_checker.sv
test/particle_euler_integrator_2d_tb.sv
